/* rtl/kdlp_pkg.sv */
// ----------------------------------------------------------------------------
// kdlp_pkg
// Shared types, codes and sizes for the key debounce and event queue block.
// ----------------------------------------------------------------------------
package kdlp_pkg;

    localparam int KEY_COUNT       = 3;
    localparam int SLOT_COUNT      = 4;
    localparam int QUEUE_DEPTH_DEF = 16;

    localparam int DB_W       = 8;
    localparam int LP_W       = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [DB_W-1:0] DEBOUNCE_RESET   = 8'd5;
    localparam logic [LP_W-1:0] LONG_PRESS_RESET = 16'd100;

    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS = 1'd1;

    // command queue between front and back
    localparam int CMDQ_DEPTH = 4;
    localparam int CMDQ_IDX_W = 2;
    localparam int CMDQ_CNT_W = 3;

    localparam logic [1:0] KIND_TICK   = 2'd0;
    localparam logic [1:0] KIND_READ   = 2'd1;
    localparam logic [1:0] KIND_RESYNC = 2'd2;

    typedef logic [3:0] event_t;

    localparam event_t EV_NONE       = 4'd0;
    localparam event_t EV_BACK_SHORT = 4'd1;
    localparam event_t EV_BACK_LONG  = 4'd2;
    localparam event_t EV_WAKE_SHORT = 4'd3;
    localparam event_t EV_WAKE_LONG  = 4'd4;
    localparam event_t EV_ENC_PRESS  = 4'd5;
    localparam event_t EV_ENC_LONG   = 4'd6;
    localparam event_t EV_CW         = 4'd7;
    localparam event_t EV_CCW        = 4'd8;

    localparam event_t EV_SHORT [KEY_COUNT] = '{EV_BACK_SHORT, EV_WAKE_SHORT, EV_ENC_PRESS};
    localparam event_t EV_LONG  [KEY_COUNT] = '{EV_BACK_LONG, EV_WAKE_LONG, EV_ENC_LONG};

    typedef enum logic [1:0] {
        OP_TICK,
        OP_READ,
        OP_CLEAR
    } op_t;

    // slots 0..2 are the keys, slot 3 the rotation
    typedef struct packed {
        op_t                         op;
        logic [SLOT_COUNT-1:0]       ev_valid;
        event_t [SLOT_COUNT-1:0]     ev_code;
    } cmd_t;

endpackage

/* rtl/kdlp_intf.sv */
// ----------------------------------------------------------------------------
// kdlp_intf
// Valid/ready channels for key items and event results.
// ----------------------------------------------------------------------------
interface kdlp_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         kind;
    logic [2:0]         raw_keys;
    logic signed [15:0] rot_steps;

    modport source (output valid, output kind, output raw_keys, output rot_steps,
                    input ready);
    modport sink   (input valid, input kind, input raw_keys, input rot_steps,
                    output ready);
endinterface

interface kdlp_out_if;
    logic       valid;
    logic       ready;
    logic [3:0] event_res;

    modport source (output valid, output event_res, input ready);
    modport sink   (input valid, input event_res, output ready);
endinterface

/* rtl/key_debounce_long_press_event_queue_core.sv */
// ----------------------------------------------------------------------------
// key_debounce_long_press_event_queue_core
// Debounces three keys, detects short and long presses and rotation, and
// queues the resulting events for reading.
// ----------------------------------------------------------------------------
// items:  tick (kind 0), read (kind 1) and resync (kind 2) items, valid/ready.
// events: one result per read item, 0 when the event queue is empty.
// cfg_we/cfg_index/cfg_data: write debounce_ticks (0) or long_press_ticks (1),
//   only while the block is idle.
// The front end takes one item per cycle, while the 4-entry command queue
// is not full; the back end pops one command at a time and writes the
// events of a tick one after another, since the event ring has a single
// write port. A read item is first written into the command queue, and its
// result is then loaded into the output register that drives events.valid.
// Reset clears key state, empties the event ring and restores the thresholds
// to 5 and 100; ring contents are not cleared and need no clearing pass.
// A stalled receiver holds the output register, the back end waits at the
// next read, the command queue fills and items.ready then drops.
// ----------------------------------------------------------------------------
module key_debounce_long_press_event_queue_core
#(
    parameter int QUEUE_DEPTH = kdlp_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    kdlp_in_if.sink                             items,
    kdlp_out_if.source                          events,
    input  logic                                cfg_we,
    input  logic [kdlp_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [kdlp_pkg::CFG_DATA_W-1:0]     cfg_data
);

    logic [kdlp_pkg::DB_W-1:0]  debounce_reg;
    logic [kdlp_pkg::LP_W-1:0]  long_press_reg;
    logic                       cmd_push;
    logic                       cmd_full;
    logic                       cmd_valid;
    logic                       cmd_pop;
    kdlp_pkg::cmd_t             cmd_new;
    kdlp_pkg::cmd_t             cmd_head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg   <= kdlp_pkg::DEBOUNCE_RESET;
            long_press_reg <= kdlp_pkg::LONG_PRESS_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                kdlp_pkg::CFG_DEBOUNCE:   debounce_reg   <= cfg_data[kdlp_pkg::DB_W-1:0];
                kdlp_pkg::CFG_LONG_PRESS: long_press_reg <= cfg_data[kdlp_pkg::LP_W-1:0];
                default:                  debounce_reg   <= debounce_reg;
            endcase
        end
    end

    kdlp_front u_front
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .items            (items),
        .debounce_ticks   (debounce_reg),
        .long_press_ticks (long_press_reg),
        .cmd_full         (cmd_full),
        .cmd_push         (cmd_push),
        .cmd              (cmd_new)
    );

    kdlp_cmd_fifo u_cmd_fifo
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (cmd_push),
        .push_cmd   (cmd_new),
        .full       (cmd_full),
        .pop        (cmd_pop),
        .head_valid (cmd_valid),
        .head_cmd   (cmd_head)
    );

    kdlp_back
    #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    )
    u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_head  (cmd_head),
        .cmd_pop   (cmd_pop),
        .events    (events)
    );

`ifndef SYNTHESIS
    a_pop_needs_head: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> cmd_valid)
        else $error("command popped from an empty queue");

    a_result_from_read: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(events.valid) |->
            $past(cmd_pop && cmd_valid && (cmd_head.op == kdlp_pkg::OP_READ)))
        else $error("result shown without a read command");

    a_stall_has_head: assert property (@(posedge clk) disable iff (!rst_n)
        !items.ready |-> cmd_valid)
        else $error("front stalled while command queue is empty");
`endif

endmodule

/* rtl/kdlp_cmd_fifo.sv */
// ----------------------------------------------------------------------------
// kdlp_cmd_fifo
// Short command queue that decouples the key front end from the event queue.
// ----------------------------------------------------------------------------
module kdlp_cmd_fifo
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  kdlp_pkg::cmd_t   push_cmd,
    output logic             full,
    input  logic             pop,
    output logic             head_valid,
    output kdlp_pkg::cmd_t   head_cmd
);

    kdlp_pkg::cmd_t                       entry_reg [kdlp_pkg::CMDQ_DEPTH];
    logic [kdlp_pkg::CMDQ_IDX_W-1:0]      head_reg;
    logic [kdlp_pkg::CMDQ_IDX_W-1:0]      tail_reg;
    logic [kdlp_pkg::CMDQ_CNT_W-1:0]      count_reg;
    logic                                 do_push;
    logic                                 do_pop;

    assign full       = (count_reg == kdlp_pkg::CMDQ_CNT_W'(kdlp_pkg::CMDQ_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = entry_reg[head_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[tail_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (do_push)
            begin
                tail_reg <= tail_reg + 1'b1;
            end
            if (do_pop)
            begin
                head_reg <= head_reg + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

/* rtl/kdlp_front.sv */
// ----------------------------------------------------------------------------
// kdlp_front
// Accepts items, debounces the keys, detects long presses and builds one
// command per tick, read or resync item for the event queue.
// ----------------------------------------------------------------------------
module kdlp_front
(
    input  logic                          clk,
    input  logic                          rst_n,
    kdlp_in_if.sink                       items,
    input  logic [kdlp_pkg::DB_W-1:0]     debounce_ticks,
    input  logic [kdlp_pkg::LP_W-1:0]     long_press_ticks,
    input  logic                          cmd_full,
    output logic                          cmd_push,
    output kdlp_pkg::cmd_t                cmd
);

    localparam int KC = kdlp_pkg::KEY_COUNT;

    logic                         stable_reg [KC];
    logic                         stable_next [KC];
    logic [kdlp_pkg::DB_W-1:0]    dc_reg [KC];
    logic [kdlp_pkg::DB_W-1:0]    dc_next [KC];
    logic [kdlp_pkg::LP_W-1:0]    hold_reg [KC];
    logic [kdlp_pkg::LP_W-1:0]    hold_next [KC];
    logic                         lr_reg [KC];
    logic                         lr_next [KC];
    logic [KC-1:0]                short_hit;
    logic [KC-1:0]                long_hit;
    logic                         accept;

    assign items.ready = !cmd_full;
    assign accept      = items.valid && items.ready;

    // per-key debounce and hold timing, keys are independent
    always_comb
    begin
        logic [kdlp_pkg::DB_W-1:0] dc_inc;
        logic [kdlp_pkg::LP_W-1:0] hold_new;
        logic                      raw;
        for (int k = 0; k < KC; k++)
        begin
            raw          = items.raw_keys[k];
            dc_inc       = dc_reg[k] + 1'b1;
            hold_new     = (hold_reg[k] < long_press_ticks) ? hold_reg[k] + 1'b1 : hold_reg[k];
            stable_next[k] = stable_reg[k];
            dc_next[k]     = dc_reg[k];
            hold_next[k]   = hold_reg[k];
            lr_next[k]     = lr_reg[k];
            short_hit[k]   = 1'b0;
            long_hit[k]    = 1'b0;
            if (raw != stable_reg[k])
            begin
                if (dc_inc >= debounce_ticks)
                begin
                    stable_next[k] = raw;
                    dc_next[k]     = '0;
                    hold_next[k]   = '0;
                    lr_next[k]     = 1'b0;
                    short_hit[k]   = !raw && !lr_reg[k];
                end
                else
                begin
                    dc_next[k] = dc_inc;
                end
            end
            else
            begin
                dc_next[k] = '0;
                if (stable_reg[k])
                begin
                    hold_next[k] = hold_new;
                    if ((hold_new >= long_press_ticks) && !lr_reg[k])
                    begin
                        lr_next[k]  = 1'b1;
                        long_hit[k] = 1'b1;
                    end
                end
            end
        end
    end

    always_comb
    begin
        cmd          = '0;
        cmd.op       = kdlp_pkg::OP_TICK;
        cmd_push     = 1'b0;
        unique case (items.kind)
            kdlp_pkg::KIND_TICK:
            begin
                cmd_push = accept;
                for (int k = 0; k < KC; k++)
                begin
                    cmd.ev_valid[k] = short_hit[k] || long_hit[k];
                    cmd.ev_code[k]  = short_hit[k] ? kdlp_pkg::EV_SHORT[k]
                                                   : kdlp_pkg::EV_LONG[k];
                end
                cmd.ev_valid[KC] = (items.rot_steps != '0);
                cmd.ev_code[KC]  = items.rot_steps[15] ? kdlp_pkg::EV_CCW
                                                       : kdlp_pkg::EV_CW;
            end
            kdlp_pkg::KIND_READ:
            begin
                cmd_push = accept;
                cmd.op   = kdlp_pkg::OP_READ;
            end
            kdlp_pkg::KIND_RESYNC:
            begin
                cmd_push = accept;
                cmd.op   = kdlp_pkg::OP_CLEAR;
            end
            default:
            begin
                cmd_push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < KC; k++)
            begin
                stable_reg[k] <= 1'b0;
                dc_reg[k]     <= '0;
                hold_reg[k]   <= '0;
                lr_reg[k]     <= 1'b0;
            end
        end
        else if (accept && (items.kind == kdlp_pkg::KIND_TICK))
        begin
            for (int k = 0; k < KC; k++)
            begin
                stable_reg[k] <= stable_next[k];
                dc_reg[k]     <= dc_next[k];
                hold_reg[k]   <= hold_next[k];
                lr_reg[k]     <= lr_next[k];
            end
        end
        else if (accept && (items.kind == kdlp_pkg::KIND_RESYNC))
        begin
            for (int k = 0; k < KC; k++)
            begin
                stable_reg[k] <= items.raw_keys[k];
                dc_reg[k]     <= '0;
                hold_reg[k]   <= '0;
                lr_reg[k]     <= 1'b0;
            end
        end
    end

endmodule

/* rtl/kdlp_back.sv */
// ----------------------------------------------------------------------------
// kdlp_back
// Event ring queue: writes the events of a tick one per cycle, pops on read
// commands into the output register, empties on resync.
// ----------------------------------------------------------------------------
module kdlp_back
#(
    parameter int QUEUE_DEPTH = kdlp_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cmd_valid,
    input  kdlp_pkg::cmd_t   cmd_head,
    output logic             cmd_pop,
    kdlp_out_if.source       events
);

    localparam int SC    = kdlp_pkg::SLOT_COUNT;
    localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);

    kdlp_pkg::event_t     ring_mem [QUEUE_DEPTH];
    logic [IDX_W-1:0]     rd_idx_reg;
    logic [IDX_W-1:0]     rd_idx_next;
    logic [IDX_W-1:0]     rd_idx_inc;
    logic [IDX_W-1:0]     wr_idx_reg;
    logic [IDX_W-1:0]     wr_idx_next;
    logic [IDX_W-1:0]     wr_idx_inc;
    logic [SC-1:0]        done_reg;
    logic [SC-1:0]        done_next;
    logic [SC-1:0]        pend;
    logic [SC-1:0]        sel;
    logic                 ring_empty;
    logic                 ring_full;
    logic                 ring_we;
    kdlp_pkg::event_t     ring_wdata;
    kdlp_pkg::event_t     out_evt_reg;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic                 out_free;
    logic                 out_load;

    assign wr_idx_inc = (wr_idx_reg == LAST_IDX) ? '0 : wr_idx_reg + 1'b1;
    assign rd_idx_inc = (rd_idx_reg == LAST_IDX) ? '0 : rd_idx_reg + 1'b1;
    assign ring_empty = (rd_idx_reg == wr_idx_reg);
    assign ring_full  = (wr_idx_inc == rd_idx_reg);
    assign out_free   = !out_valid_reg || events.ready;

    always_comb
    begin
        pend = cmd_head.ev_valid & ~done_reg;
        // lowest pending slot keeps back, wake, encoder, rotation order
        sel  = '0;
        for (int i = SC - 1; i >= 0; i--)
        begin
            if (pend[i])
            begin
                sel    = '0;
                sel[i] = 1'b1;
            end
        end
        ring_wdata = kdlp_pkg::EV_NONE;
        for (int i = 0; i < SC; i++)
        begin
            if (sel[i])
            begin
                ring_wdata = cmd_head.ev_code[i];
            end
        end

        cmd_pop     = 1'b0;
        done_next   = done_reg;
        ring_we     = 1'b0;
        rd_idx_next = rd_idx_reg;
        wr_idx_next = wr_idx_reg;
        out_load    = 1'b0;
        if (cmd_valid)
        begin
            unique case (cmd_head.op)
                kdlp_pkg::OP_TICK:
                begin
                    if (pend == '0)
                    begin
                        cmd_pop   = 1'b1;
                        done_next = '0;
                    end
                    else
                    begin
                        // full queue drops the event silently
                        ring_we = !ring_full;
                        if (!ring_full)
                        begin
                            wr_idx_next = wr_idx_inc;
                        end
                        if ((pend & ~sel) == '0)
                        begin
                            cmd_pop   = 1'b1;
                            done_next = '0;
                        end
                        else
                        begin
                            done_next = done_reg | sel;
                        end
                    end
                end
                kdlp_pkg::OP_READ:
                begin
                    if (out_free)
                    begin
                        out_load = 1'b1;
                        cmd_pop  = 1'b1;
                        if (!ring_empty)
                        begin
                            rd_idx_next = rd_idx_inc;
                        end
                    end
                end
                kdlp_pkg::OP_CLEAR:
                begin
                    rd_idx_next = '0;
                    wr_idx_next = '0;
                    cmd_pop     = 1'b1;
                end
                default:
                begin
                    cmd_pop = 1'b1;
                end
            endcase
        end

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (events.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ring_we)
        begin
            ring_mem[wr_idx_reg] <= ring_wdata;
        end
        if (out_load)
        begin
            out_evt_reg <= ring_empty ? kdlp_pkg::EV_NONE : ring_mem[rd_idx_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_idx_reg    <= '0;
            wr_idx_reg    <= '0;
            done_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rd_idx_reg    <= rd_idx_next;
            wr_idx_reg    <= wr_idx_next;
            done_reg      <= done_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign events.valid     = out_valid_reg;
    assign events.event_res = out_evt_reg;

endmodule
